[hdl/csl_pkg.sv]
// Package: payload types, register codes and reset values for the corner speed limit.
package csl_pkg;

  localparam int FracBits = 16;
  localparam int RegCount = 5;
  localparam int CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] RegMaxSpeed  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMaxAccel  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSamplePer = 3'd2;
  localparam logic [CfgIdxW-1:0] RegChordErr  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLenEps    = 3'd4;

  localparam logic [31:0] RstMaxSpeed  = 32'd6553600;
  localparam logic [31:0] RstMaxAccel  = 32'd65536000;
  localparam logic [31:0] RstSamplePer = 32'd4294967;
  localparam logic [31:0] RstChordErr  = 32'd66;
  localparam logic [31:0] RstLenEps    = 32'd1;

  localparam logic [1:0] CaseNormal    = 2'd0;
  localparam logic [1:0] CaseCollinear = 2'd1;
  localparam logic [1:0] CaseDegen     = 2'd2;

  localparam logic [31:0] Q30One = 32'h4000_0000;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] corner_x;
    logic signed [31:0] corner_y;
    logic signed [31:0] corner_z;
    logic signed [31:0] last_x;
    logic signed [31:0] last_y;
    logic signed [31:0] last_z;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] corner_speed;
    logic [1:0]  case_code;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] max_speed;
    logic [31:0] max_accel;
    logic [31:0] sample_period;
    logic [31:0] chord_error;
    logic [31:0] length_epsilon;
  } cfg_t;

endpackage

[hdl/csl_pipe_reg.sv]
// Module: one pipeline stage register with valid/ready handshake.
module csl_pipe_reg #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  logic [W-1:0] up_data,
  output logic         dn_valid,
  input  logic         dn_ready,
  output logic [W-1:0] dn_data
);
  logic         valid_r;
  logic [W-1:0] data_r;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= up_data;
    end
  end
endmodule

[hdl/csl_isqrt.sv]
// Module: pipelined floor square root, a fixed number of result bits per stage.
module csl_isqrt #(
  parameter int IW = 64,
  parameter int BPS = 4,
  parameter int TW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [IW-1:0]   in_rad,
  input  logic [TW-1:0]   in_tag,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [IW/2-1:0] out_root,
  output logic [TW-1:0]   out_tag
);
  localparam int RW = IW / 2;
  localparam int NS = RW / BPS;
  localparam int SW = IW + RW + IW + 2 + TW;

  logic [NS:0]         v;
  logic [NS:0]         rdy;
  logic [NS:0][SW-1:0] d;

  assign v[0]   = in_valid;
  assign in_ready = rdy[0];
  assign d[0]   = {in_rad, {RW{1'b0}}, {(IW + 2){1'b0}}, in_tag};

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [IW-1:0]   x;
    logic [RW-1:0]   q;
    logic [IW+1:0]   r;
    logic [TW-1:0]   t;
    logic [SW-1:0]   nx;
    always_comb begin
      logic [IW+1:0] trial;
      {x, q, r, t} = d[s];
      for (int k = 0; k < BPS; k++) begin
        r = {r[IW-1:0], x[IW-1 -: 2]};
        x = {x[IW-3:0], 2'b00};
        trial = ({{(IW+2-RW){1'b0}}, q} << 2) | (IW+2)'(1);
        if (r >= trial) begin
          r = r - trial;
          q = {q[RW-2:0], 1'b1};
        end else begin
          q = {q[RW-2:0], 1'b0};
        end
      end
      nx = {x, q, r, t};
    end
    csl_pipe_reg #(.W(SW)) u_reg (
      .clk(clk), .rst_n(rst_n),
      .up_valid(v[s]), .up_ready(rdy[s]), .up_data(nx),
      .dn_valid(v[s+1]), .dn_ready(rdy[s+1]), .dn_data(d[s+1])
    );
  end

  assign out_valid = v[NS];
  assign rdy[NS]   = out_ready;
  assign out_root  = d[NS][TW + IW + 2 +: RW];
  assign out_tag   = d[NS][TW-1:0];
endmodule

[hdl/csl_divide.sv]
// Module: pipelined restoring divider, 128/64 bit numerator over 64 bit divisor.
module csl_divide #(
  parameter int QW = 64,
  parameter int DW = 64,
  parameter int BPS = 4,
  parameter int TW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [DW-1:0] in_hi,
  input  logic [QW-1:0] in_lo,
  input  logic [DW-1:0] in_den,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [QW-1:0] out_quo,
  output logic [TW-1:0] out_tag
);
  localparam int NS = QW / BPS;
  localparam int SW = DW + QW + DW + 1 + TW;

  logic [NS:0]         v;
  logic [NS:0]         rdy;
  logic [NS:0][SW-1:0] d;

  // Overflow (hi >= den, also den zero) saturates the quotient.
  assign v[0]     = in_valid;
  assign in_ready = rdy[0];
  assign d[0]     = {in_hi, in_lo, in_den, (in_hi >= in_den), in_tag};

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [DW-1:0] r;
    logic [QW-1:0] q;
    logic [DW-1:0] den;
    logic          sat;
    logic [TW-1:0] t;
    logic [SW-1:0] nx;
    always_comb begin
      logic          top;
      {r, q, den, sat, t} = d[s];
      for (int k = 0; k < BPS; k++) begin
        top = r[DW-1];
        r   = {r[DW-2:0], q[QW-1]};
        q   = {q[QW-2:0], 1'b0};
        if (top || r >= den) begin
          r    = r - den;
          q[0] = 1'b1;
        end
      end
      nx = {r, q, den, sat, t};
    end
    csl_pipe_reg #(.W(SW)) u_reg (
      .clk(clk), .rst_n(rst_n),
      .up_valid(v[s]), .up_ready(rdy[s]), .up_data(nx),
      .dn_valid(v[s+1]), .dn_ready(rdy[s+1]), .dn_data(d[s+1])
    );
  end

  assign out_valid = v[NS];
  assign rdy[NS]   = out_ready;
  assign out_quo   = d[NS][TW] ? {QW{1'b1}} : d[NS][TW + 1 + DW +: QW];
  assign out_tag   = d[NS][TW-1:0];
endmodule

[hdl/corner_speed_limit.sv]
// Top level: corner speed limit pipeline with configuration registers.
//
// Takes three tool-path points per input beat and returns one beat with the
// allowed corner speed and a case code. The block is a fully pipelined chain:
// vector set-up and degenerate test, normalisation, dot product and lengths,
// two square roots, a 64-bit divide for the cosine, half-angle square roots,
// the chord and sampling divides and a final square root and minimum. Each
// divide and square root resolves four bits per stage, and the chain in series
// holds six set-up stages, three 8-stage square roots, two 16-stage divides
// and five single registers between them. A new beat is accepted every cycle
// while the output is not back-pressured, and back-pressure stalls the whole
// chain without loss. Configuration registers must only be written while the
// pipeline is empty.
module corner_speed_limit #(
  parameter int FRAC_BITS = csl_pkg::FracBits
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  csl_pkg::in_beat_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output csl_pkg::out_beat_t          out_data,
  input  logic                        cfg_we,
  input  logic [csl_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [31:0]                 cfg_data
);
  // Formulas are scale-free as long as all Q values share FRAC_BITS.
  localparam int TW = 32 + 2 + 1 + 1;

  csl_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_speed      <= csl_pkg::RstMaxSpeed;
      cfg_r.max_accel      <= csl_pkg::RstMaxAccel;
      cfg_r.sample_period  <= csl_pkg::RstSamplePer;
      cfg_r.chord_error    <= csl_pkg::RstChordErr;
      cfg_r.length_epsilon <= csl_pkg::RstLenEps;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        csl_pkg::RegMaxSpeed:  cfg_r.max_speed      <= cfg_data;
        csl_pkg::RegMaxAccel:  cfg_r.max_accel      <= cfg_data;
        csl_pkg::RegSamplePer: cfg_r.sample_period  <= cfg_data;
        csl_pkg::RegChordErr:  cfg_r.chord_error    <= cfg_data;
        csl_pkg::RegLenEps:    cfg_r.length_epsilon <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- stage A: segment vectors ----
  typedef struct packed {
    logic signed [32:0] ax, ay, az, bx, by, bz;
  } sa_t;
  sa_t sa_nxt, sa_q;
  logic va, ra;
  assign sa_nxt.ax = 33'(in_data.corner_x) - 33'(in_data.first_x);
  assign sa_nxt.ay = 33'(in_data.corner_y) - 33'(in_data.first_y);
  assign sa_nxt.az = 33'(in_data.corner_z) - 33'(in_data.first_z);
  assign sa_nxt.bx = 33'(in_data.last_x) - 33'(in_data.corner_x);
  assign sa_nxt.by = 33'(in_data.last_y) - 33'(in_data.corner_y);
  assign sa_nxt.bz = 33'(in_data.last_z) - 33'(in_data.corner_z);

  csl_pipe_reg #(.W($bits(sa_t))) u_sa (
    .clk, .rst_n, .up_valid(in_valid), .up_ready(in_ready), .up_data(sa_nxt),
    .dn_valid(va), .dn_ready(ra), .dn_data(sa_q));

  // ---- stage B: squares for degenerate test ----
  typedef struct packed {
    sa_t         v;
    logic [65:0] sqa0, sqa1, sqa2, sqb0, sqb1, sqb2;
  } sb_t;
  function automatic logic [32:0] mag33(logic signed [32:0] x);
    return x[32] ? 33'(-x) : 33'(x);
  endfunction
  sb_t sb_nxt, sb_q;
  logic vb, rb;
  always_comb begin
    sb_nxt.v    = sa_q;
    sb_nxt.sqa0 = mag33(sa_q.ax) * mag33(sa_q.ax);
    sb_nxt.sqa1 = mag33(sa_q.ay) * mag33(sa_q.ay);
    sb_nxt.sqa2 = mag33(sa_q.az) * mag33(sa_q.az);
    sb_nxt.sqb0 = mag33(sa_q.bx) * mag33(sa_q.bx);
    sb_nxt.sqb1 = mag33(sa_q.by) * mag33(sa_q.by);
    sb_nxt.sqb2 = mag33(sa_q.bz) * mag33(sa_q.bz);
  end
  csl_pipe_reg #(.W($bits(sb_t))) u_sb (
    .clk, .rst_n, .up_valid(va), .up_ready(ra), .up_data(sb_nxt),
    .dn_valid(vb), .dn_ready(rb), .dn_data(sb_q));

  // ---- stage C: degenerate flag and normalisation shift ----
  typedef struct packed {
    sa_t        v;
    logic       degen;
    logic [5:0] sha, shb;
  } sc_t;
  function automatic logic [5:0] norm_sh(logic [32:0] m0, logic [32:0] m1,
                                         logic [32:0] m2);
    logic [32:0] mx;
    logic [5:0]  p;
    mx = m0 | m1 | m2;
    p  = 6'd0;
    for (int i = 0; i < 33; i++) if (mx[i]) p = 6'(i);
    return p; // position of the leading one of the OR tracks the maximum's
  endfunction
  sc_t sc_nxt, sc_q;
  logic vc_, rc_;
  always_comb begin
    logic [67:0] na, nb, e2;
    na = 68'(sb_q.sqa0) + 68'(sb_q.sqa1) + 68'(sb_q.sqa2);
    nb = 68'(sb_q.sqb0) + 68'(sb_q.sqb1) + 68'(sb_q.sqb2);
    e2 = 68'(64'(cfg_r.length_epsilon) * 64'(cfg_r.length_epsilon));
    sc_nxt.v     = sb_q.v;
    sc_nxt.degen = (na <= e2) || (nb <= e2);
    sc_nxt.sha   = norm_sh(mag33(sb_q.v.ax), mag33(sb_q.v.ay), mag33(sb_q.v.az));
    sc_nxt.shb   = norm_sh(mag33(sb_q.v.bx), mag33(sb_q.v.by), mag33(sb_q.v.bz));
  end
  csl_pipe_reg #(.W($bits(sc_t))) u_sc (
    .clk, .rst_n, .up_valid(vb), .up_ready(rb), .up_data(sc_nxt),
    .dn_valid(vc_), .dn_ready(rc_), .dn_data(sc_q));

  // ---- stage D: scaled vectors (largest magnitude in [2^29,2^30)) ----
  typedef struct packed {
    logic       degen;
    logic signed [31:0] ax, ay, az, bx, by, bz;
  } sd_t;
  function automatic logic signed [31:0] scl(logic signed [32:0] x, logic [5:0] p);
    logic [32:0] m;
    logic [63:0] w;
    m = mag33(x);
    if (p >= 6'd29) w = 64'(m) >> (p - 6'd29);
    else            w = 64'(m) << (6'd29 - p);
    return x[32] ? -32'(w) : 32'(w);
  endfunction
  sd_t sd_nxt, sd_q;
  logic vd, rd;
  always_comb begin
    sd_nxt.degen = sc_q.degen;
    sd_nxt.ax = scl(sc_q.v.ax, sc_q.sha);
    sd_nxt.ay = scl(sc_q.v.ay, sc_q.sha);
    sd_nxt.az = scl(sc_q.v.az, sc_q.sha);
    sd_nxt.bx = scl(sc_q.v.bx, sc_q.shb);
    sd_nxt.by = scl(sc_q.v.by, sc_q.shb);
    sd_nxt.bz = scl(sc_q.v.bz, sc_q.shb);
  end
  csl_pipe_reg #(.W($bits(sd_t))) u_sd (
    .clk, .rst_n, .up_valid(vc_), .up_ready(rc_), .up_data(sd_nxt),
    .dn_valid(vd), .dn_ready(rd), .dn_data(sd_q));

  // ---- stage E: products ----
  typedef struct packed {
    logic degen;
    logic signed [61:0] d0, d1, d2;
    logic [59:0] a0, a1, a2, b0, b1, b2;
  } se_t;
  se_t se_nxt, se_q;
  logic ve, re;
  always_comb begin
    se_nxt.degen = sd_q.degen;
    se_nxt.d0 = 62'(sd_q.ax * sd_q.bx);
    se_nxt.d1 = 62'(sd_q.ay * sd_q.by);
    se_nxt.d2 = 62'(sd_q.az * sd_q.bz);
    se_nxt.a0 = 60'(sd_q.ax * sd_q.ax);
    se_nxt.a1 = 60'(sd_q.ay * sd_q.ay);
    se_nxt.a2 = 60'(sd_q.az * sd_q.az);
    se_nxt.b0 = 60'(sd_q.bx * sd_q.bx);
    se_nxt.b1 = 60'(sd_q.by * sd_q.by);
    se_nxt.b2 = 60'(sd_q.bz * sd_q.bz);
  end
  csl_pipe_reg #(.W($bits(se_t))) u_se (
    .clk, .rst_n, .up_valid(vd), .up_ready(rd), .up_data(se_nxt),
    .dn_valid(ve), .dn_ready(re), .dn_data(se_q));

  // ---- stage F: sums ----
  typedef struct packed {
    logic degen;
    logic signed [63:0] dot;
    logic [63:0] n0, n1;
  } sf_t;
  sf_t sf_nxt, sf_q;
  logic vf, rf;
  always_comb begin
    sf_nxt.degen = se_q.degen;
    sf_nxt.dot = 64'(se_q.d0) + 64'(se_q.d1) + 64'(se_q.d2);
    sf_nxt.n0  = 64'(se_q.a0) + 64'(se_q.a1) + 64'(se_q.a2);
    sf_nxt.n1  = 64'(se_q.b0) + 64'(se_q.b1) + 64'(se_q.b2);
  end
  csl_pipe_reg #(.W($bits(sf_t))) u_sf (
    .clk, .rst_n, .up_valid(ve), .up_ready(re), .up_data(sf_nxt),
    .dn_valid(vf), .dn_ready(rf), .dn_data(sf_q));

  // ---- lengths: two square roots side by side (joined handshake) ----
  localparam int T1 = 1 + 64 + 64;
  logic [T1-1:0] l0_tag, l1_tag;
  logic [31:0] l0, l1;
  logic vl0, vl1, rl0, rl1, rl, vl;
  assign rf = rl0 && rl1;
  csl_isqrt #(.IW(64), .BPS(4), .TW(T1)) u_len0 (
    .clk, .rst_n, .in_valid(vf && rl1), .in_ready(rl0), .in_rad(sf_q.n0),
    .in_tag({sf_q.degen, sf_q.dot, sf_q.n1}), .out_valid(vl0), .out_ready(rl && vl1),
    .out_root(l0), .out_tag(l0_tag));
  csl_isqrt #(.IW(64), .BPS(4), .TW(T1)) u_len1 (
    .clk, .rst_n, .in_valid(vf && rl0), .in_ready(rl1), .in_rad(sf_q.n1),
    .in_tag({sf_q.degen, sf_q.dot, sf_q.n1}), .out_valid(vl1), .out_ready(rl && vl0),
    .out_root(l1), .out_tag(l1_tag));
  assign vl = vl0 && vl1;

  // ---- stage G: length product ----
  typedef struct packed {
    logic degen;
    logic signed [63:0] dot;
    logic [63:0] lp;
  } sg_t;
  sg_t sg_nxt, sg_q;
  logic vg, rg;
  always_comb begin
    sg_nxt.degen = l0_tag[T1-1];
    sg_nxt.dot   = l0_tag[127:64];
    sg_nxt.lp    = 64'(l0) * 64'(l1);
  end
  csl_pipe_reg #(.W($bits(sg_t))) u_sg (
    .clk, .rst_n, .up_valid(vl), .up_ready(rl), .up_data(sg_nxt),
    .dn_valid(vg), .dn_ready(rg), .dn_data(sg_q));

  // ---- cosine divide ----
  logic [63:0] ad, cq;
  logic [1:0]  cos_tag;
  logic vcq, rcq;
  assign ad = sg_q.dot[63] ? 64'(-sg_q.dot) : 64'(sg_q.dot);
  csl_divide #(.QW(64), .DW(64), .BPS(4), .TW(2)) u_cos (
    .clk, .rst_n, .in_valid(vg), .in_ready(rg),
    .in_hi(ad >> 34), .in_lo(ad << 30),
    .in_den(sg_q.lp), .in_tag({sg_q.degen, sg_q.dot[63] && (sg_q.lp != 64'd0)}),
    .out_valid(vcq), .out_ready(rcq), .out_quo(cq), .out_tag(cos_tag));

  // ---- stage H: signed clamped cosine and case ----
  typedef struct packed {
    logic [1:0]  code;
    logic [31:0] onepc, onemc; // 1+c and 1-c in Q2.30, each <= 2^31
  } sh_t;
  sh_t sh_nxt, sh_q;
  logic vh, rh;
  always_comb begin
    logic [31:0] q;
    q = (cq > 64'(csl_pkg::Q30One)) ? csl_pkg::Q30One : cq[31:0];
    if (cos_tag[1]) begin
      sh_nxt.code  = csl_pkg::CaseDegen;
      sh_nxt.onepc = csl_pkg::Q30One;
      sh_nxt.onemc = csl_pkg::Q30One;
    end else begin
      sh_nxt.code  = (!cos_tag[0] && q == csl_pkg::Q30One) ? csl_pkg::CaseCollinear
                                                            : csl_pkg::CaseNormal;
      sh_nxt.onepc = cos_tag[0] ? csl_pkg::Q30One - q : csl_pkg::Q30One + q;
      sh_nxt.onemc = cos_tag[0] ? csl_pkg::Q30One + q : csl_pkg::Q30One - q;
    end
  end
  csl_pipe_reg #(.W($bits(sh_t))) u_sh (
    .clk, .rst_n, .up_valid(vcq), .up_ready(rcq), .up_data(sh_nxt),
    .dn_valid(vh), .dn_ready(rh), .dn_data(sh_q));

  // ---- half angle roots ----
  logic [31:0] chr, shr;
  logic [1:0] h0_tag, h1_tag;
  logic vh0, vh1, rh0, rh1, rj;
  assign rh = rh0 && rh1;
  csl_isqrt #(.IW(64), .BPS(4), .TW(2)) u_ch (
    .clk, .rst_n, .in_valid(vh && rh1), .in_ready(rh0),
    .in_rad(64'(sh_q.onepc) << 29), .in_tag(sh_q.code),
    .out_valid(vh0), .out_ready(rj && vh1), .out_root(chr), .out_tag(h0_tag));
  csl_isqrt #(.IW(64), .BPS(4), .TW(2)) u_sh2 (
    .clk, .rst_n, .in_valid(vh && rh0), .in_ready(rh1),
    .in_rad(64'(sh_q.onemc) << 29), .in_tag(sh_q.code),
    .out_valid(vh1), .out_ready(rj && vh0), .out_root(shr), .out_tag(h1_tag));

  // ---- stage J: products for the two limits ----
  typedef struct packed {
    logic [1:0]  code;
    logic [31:0] ch, sh;
    logic [63:0] ac, at;
  } sj_t;
  sj_t sj_nxt, sj_q;
  logic vj, rjq;
  always_comb begin
    sj_nxt.code = h0_tag;
    sj_nxt.ch   = chr;
    sj_nxt.sh   = shr;
    sj_nxt.ac   = 64'(cfg_r.max_accel) * 64'(cfg_r.chord_error);
    sj_nxt.at   = 64'(cfg_r.max_accel) * 64'(cfg_r.sample_period);
  end
  csl_pipe_reg #(.W($bits(sj_t))) u_sj (
    .clk, .rst_n, .up_valid(vh0 && vh1), .up_ready(rj), .up_data(sj_nxt),
    .dn_valid(vj), .dn_ready(rjq), .dn_data(sj_q));

  // ---- stage K: ac*ch as partial products (64x32) ----
  typedef struct packed {
    logic [1:0]  code;
    logic [31:0] ch, sh;
    logic [63:0] at;
    logic [63:0] plo, phi;
  } sk_t;
  sk_t sk_nxt, sk_q;
  logic vk, rk;
  always_comb begin
    sk_nxt.code = sj_q.code;
    sk_nxt.ch   = sj_q.ch;
    sk_nxt.sh   = sj_q.sh;
    sk_nxt.at   = sj_q.at;
    sk_nxt.plo  = 64'(sj_q.ac[31:0]) * 64'(sj_q.ch);
    sk_nxt.phi  = 64'(sj_q.ac[63:32]) * 64'(sj_q.ch);
  end
  csl_pipe_reg #(.W($bits(sk_t))) u_sk (
    .clk, .rst_n, .up_valid(vj), .up_ready(rjq), .up_data(sk_nxt),
    .dn_valid(vk), .dn_ready(rk), .dn_data(sk_q));

  // ---- two divides in parallel ----
  logic [95:0] num;
  assign num = 96'(sk_q.plo) + (96'(sk_q.phi) << 32);
  logic [63:0] qc, qt;
  logic [1:0]  dc_tag, dt_tag;
  logic vdc, vdt, rdc, rdt, rm;
  assign rk = rdc && rdt;
  // vt quotient < 2^64/2^3, so hi word always below the divisor when sh != 0
  csl_divide #(.QW(64), .DW(64), .BPS(4), .TW(2)) u_dchord (
    .clk, .rst_n, .in_valid(vk && rdt), .in_ready(rdc),
    .in_hi(64'(num[95:64])), .in_lo(num[63:0]),
    .in_den(64'(csl_pkg::Q30One - sk_q.ch)), .in_tag(sk_q.code),
    .out_valid(vdc), .out_ready(rm && vdt), .out_quo(qc), .out_tag(dc_tag));
  csl_divide #(.QW(64), .DW(64), .BPS(4), .TW(2)) u_dsamp (
    .clk, .rst_n, .in_valid(vk && rdc), .in_ready(rdt),
    .in_hi(64'd0), .in_lo(sk_q.at),
    .in_den(64'(sk_q.sh) << 3), .in_tag({1'b0, sk_q.sh == 32'd0}),
    .out_valid(vdt), .out_ready(rm && vdc), .out_quo(qt), .out_tag(dt_tag));

  // ---- stage M: chord root input ----
  logic [31:0] vcr;
  logic [TW-1:0] rt_tag;
  logic vr, rr;
  csl_isqrt #(.IW(64), .BPS(4), .TW(TW)) u_vc (
    .clk, .rst_n, .in_valid(vdc && vdt), .in_ready(rm), .in_rad(qc),
    .in_tag({(qt > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : qt[31:0], dc_tag, dt_tag[0],
             1'b0}),
    .out_valid(vr), .out_ready(rr), .out_root(vcr), .out_tag(rt_tag));

  // ---- output stage: minimum ----
  csl_pkg::out_beat_t ob_nxt;
  always_comb begin
    logic [31:0] res, vt;
    vt  = rt_tag[1] ? 32'd0 : rt_tag[TW-1 -: 32];
    res = cfg_r.max_speed;
    if (rt_tag[3:2] != csl_pkg::CaseCollinear) begin
      if (vcr < res) res = vcr;
      if (vt < res)  res = vt;
    end
    ob_nxt.corner_speed = res;
    ob_nxt.case_code    = rt_tag[3:2];
  end
  csl_pipe_reg #(.W($bits(csl_pkg::out_beat_t))) u_out (
    .clk, .rst_n, .up_valid(vr), .up_ready(rr), .up_data(ob_nxt),
    .dn_valid(out_valid), .dn_ready(out_ready), .dn_data(out_data));

`ifndef SYNTHESIS
  a_case_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.case_code <= csl_pkg::CaseDegen) else $error("bad case code");
  a_collinear_speed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.case_code == csl_pkg::CaseCollinear
      |-> out_data.corner_speed == cfg_r.max_speed) else $error("collinear speed");
  a_speed_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.corner_speed <= cfg_r.max_speed) else $error("speed cap");
  a_len_pair: assert property (@(posedge clk) disable iff (!rst_n)
    vl0 == vl1) else $error("length roots out of step");
`endif
endmodule

[bench/tb.sv]
// Testbench for the corner speed limit: predicted corner speeds and case codes checked beat by beat.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] Q30 = 64'h4000_0000;
  localparam int DrainCycles = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  csl_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  csl_pkg::out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [csl_pkg::CfgIdxW-1:0] cfg_idx = '0;
  logic [31:0] cfg_data = '0;
  logic in_took = 1'b0;  // input beat accepted at the last rising edge

  always #6 clk = ~clk;

  corner_speed_limit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  // Predictor's own copy of the registers
  csl_pkg::cfg_t lim;

  csl_pkg::in_beat_t  corner_q[$];  // corners waiting for the driver
  csl_pkg::out_beat_t speed_q[$];   // predicted results, oldest first
  int errors = 0;
  int n_sent = 0;
  int n_got = 0;
  int n_cfg = 0;
  int send_idle = 0;   // percent of cycles the sender holds back
  int recv_stall = 0;  // percent of cycles the receiver stalls
  int hold_off = 0;    // cycles of forced receiver hold-off still to run
  int n_case[3] = '{0, 0, 0};

  function automatic logic [63:0] sqrt_floor(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // floor(n / d) saturating at 2^64 - 1
  function automatic logic [63:0] div_sat(logic [127:0] n, logic [63:0] d);
    logic [127:0] q;
    q = n / d;
    return (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
  endfunction

  // Segment at or below length_epsilon (exact squared length compare)
  function automatic bit seg_short(logic signed [63:0] v[3]);
    logic [127:0] s, e;
    s = 0;
    for (int i = 0; i < 3; i++) s += 128'(v[i]) * 128'(v[i]);
    e = 128'(lim.length_epsilon) * 128'(lim.length_epsilon);
    e = 128'(e[63:0]);  // squared epsilon is held in 64 bits
    return s <= e;
  endfunction

  // Normalise so the largest magnitude lies in [2^29, 2^30); shifts truncate magnitudes
  function automatic void norm_vec(logic signed [63:0] v[3], output logic signed [63:0] o[3]);
    logic [63:0] m[3], mx;
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = v[i] < 0 ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx != 0) begin
      while (mx >= (64'd1 << 30)) begin
        mx >>= 1;
        for (int i = 0; i < 3; i++) m[i] >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
        mx <<= 1;
        for (int i = 0; i < 3; i++) m[i] <<= 1;
      end
    end
    for (int i = 0; i < 3; i++) o[i] = v[i] < 0 ? -$signed(m[i]) : $signed(m[i]);
  endfunction

  function automatic csl_pkg::out_beat_t corner_speed_of(csl_pkg::in_beat_t p);
    logic signed [63:0] a[3], b[3], sa[3], sb[3], dot, c;
    logic [63:0] n0, n1, lp, q, ad, ch, sh, vt, vc, res;
    csl_pkg::out_beat_t r;
    a[0] = 64'(p.corner_x) - 64'(p.first_x);
    a[1] = 64'(p.corner_y) - 64'(p.first_y);
    a[2] = 64'(p.corner_z) - 64'(p.first_z);
    b[0] = 64'(p.last_x) - 64'(p.corner_x);
    b[1] = 64'(p.last_y) - 64'(p.corner_y);
    b[2] = 64'(p.last_z) - 64'(p.corner_z);
    if (seg_short(a) || seg_short(b)) begin
      c = 0;
      r.case_code = csl_pkg::CaseDegen;
    end else begin
      norm_vec(a, sa);
      norm_vec(b, sb);
      dot = 0; n0 = 0; n1 = 0;
      for (int i = 0; i < 3; i++) begin
        dot += sa[i] * sb[i];
        n0 += sa[i] * sa[i];
        n1 += sb[i] * sb[i];
      end
      lp = sqrt_floor(n0) * sqrt_floor(n1);
      ad = dot < 0 ? -dot : dot;
      q = lp != 0 ? div_sat({34'd0, ad, 30'd0}, lp) : 0;
      if (q > Q30) q = Q30;
      c = dot < 0 ? -$signed(q) : $signed(q);
      r.case_code = csl_pkg::CaseNormal;
      if (c == $signed(Q30)) begin
        r.corner_speed = lim.max_speed;
        r.case_code = csl_pkg::CaseCollinear;
        return r;
      end
    end
    ch = sqrt_floor(64'(Q30 + c) << 29);
    sh = sqrt_floor(64'(Q30 - c) << 29);
    vt = sh != 0 ? (64'(lim.max_accel) * 64'(lim.sample_period)) / (64'd8 * sh) : 0;
    vc = sqrt_floor(div_sat(128'(64'(64'(lim.max_accel) * 64'(lim.chord_error))) * 128'(ch),
                            Q30 - ch));
    res = 64'(lim.max_speed);
    if (vc < res) res = vc;
    if (vt < res) res = vt;
    r.corner_speed = res[31:0];
    return r;
  endfunction

  // Input handshake as seen at the rising edge
  always @(posedge clk) begin
    in_took <= rst_n && in_valid && in_ready;
  end

  // Driver: offers queued corners; predicts each one as it is accepted
  always @(negedge clk) begin
    if (in_took) begin
      speed_q = {speed_q, corner_speed_of(in_data)};
      n_sent++;
    end
    if (!in_valid || in_took) begin
      if (corner_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        in_valid <= 1'b1;
        in_data <= corner_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: long hold-off counted here, else random stalls
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // Monitor: compares each accepted result with the oldest prediction
  always @(posedge clk) begin
    csl_pkg::out_beat_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      n_got++;
      if (speed_q.size() == 0) begin
        $error("unexpected result beat: speed %0d case %0d",
               out_data.corner_speed, out_data.case_code);
        errors++;
      end else begin
        exp_r = speed_q.pop_front();
        n_case[exp_r.case_code]++;
        if (out_data.corner_speed !== exp_r.corner_speed) begin
          $error("corner_speed: expected %0d, got %0d", exp_r.corner_speed,
                 out_data.corner_speed);
          errors++;
        end
        if (out_data.case_code !== exp_r.case_code) begin
          $error("case_code: expected %0d, got %0d", exp_r.case_code, out_data.case_code);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [csl_pkg::CfgIdxW-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      csl_pkg::RegMaxSpeed:  lim.max_speed = val;
      csl_pkg::RegMaxAccel:  lim.max_accel = val;
      csl_pkg::RegSamplePer: lim.sample_period = val;
      csl_pkg::RegChordErr:  lim.chord_error = val;
      csl_pkg::RegLenEps:    lim.length_epsilon = val;
      default: ;
    endcase
    n_cfg++;
  endtask

  // Wait for the pipeline to run dry: nothing queued, nothing predicted
  task automatic drain();
    while (corner_q.size() != 0 || in_valid || speed_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'($signed($urandom_range(2000)) - 1000);
      default: return 32'($signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
    endcase
  endfunction

  // Random corner: mostly plausible paths, some collinear, reversed or degenerate
  function automatic csl_pkg::in_beat_t rnd_corner();
    csl_pkg::in_beat_t p;
    logic signed [31:0] dx, dy, dz;
    int k;
    p = {rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
         rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
    dx = $signed($urandom_range(4000)) - 2000;
    dy = $signed($urandom_range(4000)) - 2000;
    dz = $signed($urandom_range(400)) - 200;
    k = $urandom_range(1, 3);
    case ($urandom_range(9))
      0: begin  // collinear, same direction
        p.first_x = p.corner_x - dx; p.first_y = p.corner_y - dy; p.first_z = p.corner_z - dz;
        p.last_x = p.corner_x + k * dx; p.last_y = p.corner_y + k * dy;
        p.last_z = p.corner_z + k * dz;
      end
      1: begin  // reversal
        p.first_x = p.corner_x - dx; p.first_y = p.corner_y - dy; p.first_z = p.corner_z - dz;
        p.last_x = p.first_x; p.last_y = p.first_y; p.last_z = p.first_z;
      end
      2: begin  // degenerate first segment
        p.first_x = p.corner_x + $signed($urandom_range(2)) - 1;
        p.first_y = p.corner_y; p.first_z = p.corner_z;
      end
      3: begin  // degenerate last segment
        p.last_x = p.corner_x; p.last_y = p.corner_y;
        p.last_z = p.corner_z + $signed($urandom_range(2)) - 1;
      end
      4, 5, 6, 7: begin  // nearby points
        p.first_x = p.corner_x - dx; p.first_y = p.corner_y - dy; p.first_z = p.corner_z - dz;
        p.last_x = p.corner_x + 32'($signed($urandom_range(40000)) - 20000);
        p.last_y = p.corner_y + 32'($signed($urandom_range(40000)) - 20000);
        p.last_z = p.corner_z + 32'($signed($urandom_range(400)) - 200);
      end
      default: ;  // fully random, wraps at the extremes
    endcase
    return p;
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    send_idle = idle;
    recv_stall = stall;
    repeat (n) corner_q = {corner_q, rnd_corner()};
  endtask

  initial begin
    csl_pkg::in_beat_t p;
    lim = '{csl_pkg::RstMaxSpeed, csl_pkg::RstMaxAccel, csl_pkg::RstSamplePer,
            csl_pkg::RstChordErr, csl_pkg::RstLenEps};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed corners at reset settings
    p = '0; p.corner_x = 32'sd65536; p.last_x = 32'sd131072;
    corner_q = {corner_q, p};                               // collinear
    p.last_x = 32'sd65536; p.last_y = 32'sd65536;
    corner_q = {corner_q, p};                               // right angle
    p.last_x = 32'sd0; p.last_y = 32'sd0;
    corner_q = {corner_q, p};                               // reversal
    p = '0;
    corner_q = {corner_q, p};                               // both segments zero
    p.corner_x = 32'sd1; p.last_x = 32'sd5; p.last_y = 32'sd3;
    corner_q = {corner_q, p};                               // length exactly epsilon
    p = {9{32'h8000_0000}}; p.corner_x = 32'h7FFF_FFFF; p.last_z = 32'h7FFF_FFFF;
    corner_q = {corner_q, p};                               // extreme coordinates
    p = {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0,
         32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
    corner_q = {corner_q, p};
    p = {32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0};
    corner_q = {corner_q, p};                               // tiny segments
    p = '0; p.corner_x = 32'sd65536; p.last_x = 32'sd131072; p.last_y = 32'sd1;
    corner_q = {corner_q, p};                               // nearly straight
    p.last_x = 32'sd65537; p.last_y = 32'sd0;
    corner_q = {corner_q, p};
    repeat (8) corner_q = {corner_q, rnd_corner()};
    drain();

    // Every register at its extremes, then random settings
    write_reg(csl_pkg::RegMaxSpeed, 32'hFFFF_FFFF);
    write_reg(csl_pkg::RegMaxAccel, 32'hFFFF_FFFF);
    write_reg(csl_pkg::RegSamplePer, 32'hFFFF_FFFF);
    write_reg(csl_pkg::RegChordErr, 32'hFFFF_FFFF);
    write_reg(csl_pkg::RegLenEps, 32'hFFFF_FFFF);
    random_phase(80, 0, 0);
    drain();

    write_reg(csl_pkg::RegMaxSpeed, 32'd0);
    write_reg(csl_pkg::RegMaxAccel, 32'd0);
    write_reg(csl_pkg::RegSamplePer, 32'd0);
    write_reg(csl_pkg::RegChordErr, 32'd0);
    write_reg(csl_pkg::RegLenEps, 32'd0);
    random_phase(60, 83, 0);
    drain();

    write_reg(csl_pkg::RegMaxSpeed, csl_pkg::RstMaxSpeed);
    write_reg(csl_pkg::RegMaxAccel, csl_pkg::RstMaxAccel);
    write_reg(csl_pkg::RegSamplePer, 32'd1);
    write_reg(csl_pkg::RegChordErr, csl_pkg::RstChordErr);
    write_reg(csl_pkg::RegLenEps, 32'd3);
    random_phase(80, 0, 83);
    drain();

    // Receiver holds off while the sender keeps going, filling the pipeline
    write_reg(csl_pkg::RegSamplePer, csl_pkg::RstSamplePer);
    write_reg(csl_pkg::RegLenEps, csl_pkg::RstLenEps);
    hold_off = 300;
    random_phase(150, 0, 0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_reg(csl_pkg::RegMaxSpeed, $urandom);
      write_reg(csl_pkg::RegMaxAccel, $urandom);
      write_reg(csl_pkg::RegSamplePer, $urandom);
      write_reg(csl_pkg::RegChordErr, $urandom_range(1) ? $urandom_range(5000) : $urandom);
      write_reg(csl_pkg::RegLenEps, $urandom_range(200));
      random_phase(60, (ph % 2) ? 7 : 83, (ph % 2) ? 7 : 83);
      drain();
    end

    $display("Sent %0d corners, checked %0d results over %0d register writes.",
             n_sent, n_got, n_cfg);
    $display("Cases seen: %0d normal, %0d collinear, %0d degenerate.",
             n_case[0], n_case[1], n_case[2]);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

[filelist.f]
hdl/csl_pkg.sv
hdl/csl_pipe_reg.sv
hdl/csl_isqrt.sv
hdl/csl_divide.sv
hdl/corner_speed_limit.sv
bench/tb.sv
